[rtl/serial_drive_command_mixer_defines.svh]
// ----------------------------------------------------------------------------
// Serial drive command mixer: assertion macros
// Property wrappers for the mixer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SERIAL_DRIVE_COMMAND_MIXER_DEFINES_SVH
`define SERIAL_DRIVE_COMMAND_MIXER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define SDCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define SDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sdcm_pkg.sv]
// ----------------------------------------------------------------------------
// Serial drive command mixer package
// States, command bytes, arithmetic constants and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdcm_pkg;

    // Field widths
    localparam int RX_W    = 8;
    localparam int TRACK_W = 7;
    localparam int CMP_W   = 13;

    // Command bytes
    localparam logic [RX_W-1:0] CH_START   = 8'd58;   // ':'
    localparam logic [RX_W-1:0] CH_LINEAR  = 8'd115;  // 's'
    localparam logic [RX_W-1:0] CH_ANGULAR = 8'd97;   // 'a'
    localparam logic [RX_W-1:0] CH_ESC     = 8'd27;
    localparam logic [RX_W-1:0] CH_MINUS   = 8'd45;   // '-'

    // Track term after reset
    localparam logic [TRACK_W-1:0] TRACK_RESET = 7'd44;

    // Divide by 100: x * 5243 >> 19 is exact for x below 2^15
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          Q_SHIFT   = 19;

    // PWM compare: (125 * |v| - 7) / 10, divide by 10 as x * 52429 >> 19
    localparam logic [15:0] PWM_GAIN   = 16'd125;
    localparam logic [15:0] PWM_OFFSET = 16'd7;
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam int          CMP_SHIFT  = 19;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECV,
        S_LIN_SIGN,
        S_LIN_MAG,
        S_ANG_SIGN,
        S_ANG_MAG,
        S_MUL,
        S_DIV,
        S_MIX,
        S_SCALE,
        S_CMP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load_sign;
        logic load_lin;
        logic load_ang;
        logic step_mul;
        logic step_div;
        logic step_mix;
        logic step_scale;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/sdcm_if.sv]
// ----------------------------------------------------------------------------
// Serial drive command mixer channels
// Valid/ready channels for command bytes and wheel drive results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdcm_cmd_if
    import sdcm_pkg::*;
    ;
    logic            valid;
    logic            ready;
    logic [RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdcm_drv_if
    import sdcm_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [CMP_W-1:0] left_compare;
    logic [CMP_W-1:0] right_compare;
    logic             left_forward;
    logic             right_forward;

    modport source (output valid, output left_compare, output right_compare,
                    output left_forward, output right_forward, input ready);
    modport sink   (input valid, input left_compare, input right_compare,
                    input left_forward, input right_forward, output ready);
endinterface

`default_nettype wire

[rtl/serial_drive_command_mixer.sv]
// ----------------------------------------------------------------------------
// Serial drive command mixer
// Parses serial speed commands and emits differential wheel PWM settings.
//
// Channel   Dir  Payload                                   Handshake
// i_cmd     in   rx_byte[7:0]                              valid/ready
// o_drv     out  left/right_compare[12:0], left/right_fwd  valid/ready
// i_cfg_*   in   track_percent[6:0]                        write enable
//
// A command byte is taken on each valid/ready handshake. ESC while
// receiving runs the mix sequence (multiply, divide by 100, mix, scale,
// compare), during which no byte is taken. The last step waits if the
// result register still holds an untaken result. Reset is synchronous,
// active low; it sets the track term to 44 and clears parser and speeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_drive_command_mixer
    import sdcm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [TRACK_W-1:0] i_cfg_wdata,
    sdcm_cmd_if.sink                i_cmd,
    sdcm_drv_if.source              o_drv
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    assign i_cmd.ready = w_cmd.in_ready;

    // Parser and sequencer
    sdcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_rx_byte  (i_cmd.rx_byte),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and result register
    sdcm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_byte       (i_cmd.rx_byte),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (o_drv.ready),
        .o_out_valid     (o_drv.valid),
        .o_left_compare  (o_drv.left_compare),
        .o_right_compare (o_drv.right_compare),
        .o_left_forward  (o_drv.left_forward),
        .o_right_forward (o_drv.right_forward)
    );

endmodule

`default_nettype wire

[rtl/sdcm_ctrl.sv]
// ----------------------------------------------------------------------------
// Serial drive command mixer controller
// Parses the command byte stream and sequences the mixing datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "serial_drive_command_mixer_defines.svh"

module sdcm_ctrl
    import sdcm_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [RX_W-1:0] i_rx_byte,
    input  wire t_dp_status      i_status,
    output t_ctrl_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && o_cmd.in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_rx_byte == CH_START)) begin
                    n_state = S_RECV;
                end
            end
            S_RECV: begin
                if (w_accept) begin
                    if (i_rx_byte == CH_LINEAR) begin
                        n_state = S_LIN_SIGN;
                    end else if (i_rx_byte == CH_ANGULAR) begin
                        n_state = S_ANG_SIGN;
                    end else if (i_rx_byte == CH_ESC) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_LIN_SIGN: begin
                if (w_accept) begin
                    n_state = S_LIN_MAG;
                end
            end
            S_ANG_SIGN: begin
                if (w_accept) begin
                    n_state = S_ANG_MAG;
                end
            end
            S_LIN_MAG, S_ANG_MAG: begin
                if (w_accept) begin
                    n_state = S_RECV;
                end
            end
            S_MUL:   n_state = S_DIV;
            S_DIV:   n_state = S_MIX;
            S_MIX:   n_state = S_SCALE;
            S_SCALE: n_state = S_CMP;
            S_CMP: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE, S_RECV: begin
                o_cmd.in_ready = 1'b1;
            end
            S_LIN_SIGN, S_ANG_SIGN: begin
                o_cmd.in_ready  = 1'b1;
                o_cmd.load_sign = i_in_valid;
            end
            S_LIN_MAG: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load_lin = i_in_valid;
            end
            S_ANG_MAG: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load_ang = i_in_valid;
            end
            S_MUL:   o_cmd.step_mul   = 1'b1;
            S_DIV:   o_cmd.step_div   = 1'b1;
            S_MIX:   o_cmd.step_mix   = 1'b1;
            S_SCALE: o_cmd.step_scale = 1'b1;
            S_CMP:   o_cmd.load_out   = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // ESC while receiving starts the mixing sequence
    `SDCM_ASSERT_NEXT(a_esc_starts_mix, i_clk, i_rst_n,
        (r_state == S_RECV) && i_in_valid && (i_rx_byte == CH_ESC),
        r_state == S_MUL, "ESC in receive did not start mixing")

    // Stored speeds stay put while the mix is computed
    `SDCM_ASSERT_NOW(a_speeds_hold, i_clk, i_rst_n,
        (r_state == S_MUL) || (r_state == S_DIV) || (r_state == S_MIX) ||
        (r_state == S_SCALE) || (r_state == S_CMP),
        !(o_cmd.in_ready || o_cmd.load_sign || o_cmd.load_lin || o_cmd.load_ang),
        "speed register loaded during mixing")

    // A handed-off result returns the parser to idle
    `SDCM_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n,
        (r_state == S_CMP) && i_status.out_free,
        r_state == S_IDLE, "parser did not return to idle after result")

endmodule

`default_nettype wire

[rtl/sdcm_dp.sv]
// ----------------------------------------------------------------------------
// Serial drive command mixer datapath
// Speed registers, differential mix arithmetic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdcm_dp
    import sdcm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [TRACK_W-1:0] i_cfg_wdata,
    input  wire logic [RX_W-1:0]    i_rx_byte,
    input  wire t_ctrl_cmd          i_cmd,
    output t_dp_status              o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [CMP_W-1:0]        o_left_compare,
    output logic [CMP_W-1:0]        o_right_compare,
    output logic                    o_left_forward,
    output logic                    o_right_forward
);

    // Halve toward zero
    function automatic logic [9:0] half_tz(input logic [10:0] s);
        logic [10:0] a;
        a = s + {10'd0, s[10]};
        return a[10:1];
    endfunction

    // Magnitude of a wheel speed, at most 416
    function automatic logic [8:0] mag10(input logic [9:0] v);
        logic [9:0] n;
        n = ~v + 10'd1;
        return v[9] ? n[8:0] : v[8:0];
    endfunction

    logic [TRACK_W-1:0] r_track;
    logic               r_neg_pend;
    logic [8:0]         r_lin;
    logic [8:0]         r_ang;
    logic [15:0]        r_prod;
    logic               r_tneg;
    logic [8:0]         r_q;
    logic [8:0]         r_lmag;
    logic [8:0]         r_rmag;
    logic               r_lfwd;
    logic               r_rfwd;
    logic [15:0]        r_lnum;
    logic [15:0]        r_rnum;
    logic               r_out_valid;
    logic [CMP_W-1:0]   r_lcmp;
    logic [CMP_W-1:0]   r_rcmp;
    logic               r_lfwd_out;
    logic               r_rfwd_out;

    logic [8:0]  w_mag;
    logic [8:0]  w_smag;
    logic [8:0]  w_ang_abs;
    logic [28:0] w_qprod;
    logic [10:0] w_t;
    logic [10:0] w_lin2;
    logic [9:0]  w_left;
    logic [9:0]  w_right;
    logic [31:0] w_lcprod;
    logic [31:0] w_rcprod;

    // Track register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= TRACK_RESET;
        end else if (i_cfg_we) begin
            r_track <= i_cfg_wdata;
        end
    end

    // Sign and speed registers
    assign w_mag  = {1'b0, i_rx_byte};
    assign w_smag = r_neg_pend ? (~w_mag + 9'd1) : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_pend <= 1'b0;
            r_lin      <= '0;
            r_ang      <= '0;
        end else begin
            if (i_cmd.load_sign) begin
                r_neg_pend <= (i_rx_byte == CH_MINUS);
            end
            if (i_cmd.load_lin) begin
                r_lin <= w_smag;
            end
            if (i_cmd.load_ang) begin
                r_ang <= w_smag;
            end
        end
    end

    // Mix arithmetic, one step per cycle
    assign w_ang_abs = r_ang[8] ? (~r_ang + 9'd1) : r_ang;
    assign w_qprod   = 29'(r_prod) * 29'(RECIP_100);
    assign w_t       = r_tneg ? (~{2'b00, r_q} + 11'd1) : {2'b00, r_q};
    assign w_lin2    = {r_lin[8], r_lin, 1'b0};
    assign w_left    = half_tz(w_lin2 - w_t);
    assign w_right   = half_tz(w_lin2 + w_t);
    assign w_lcprod  = 32'(r_lnum) * 32'(RECIP_10);
    assign w_rcprod  = 32'(r_rnum) * 32'(RECIP_10);

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_mul) begin
            r_prod <= 16'(w_ang_abs) * 16'(r_track);
            r_tneg <= r_ang[8];
        end
        if (i_cmd.step_div) begin
            r_q <= w_qprod[Q_SHIFT +: 9];
        end
        if (i_cmd.step_mix) begin
            r_lmag <= mag10(w_left);
            r_rmag <= mag10(w_right);
            r_lfwd <= !w_left[9];
            r_rfwd <= !w_right[9];
        end
        if (i_cmd.step_scale) begin
            r_lnum <= 16'(r_lmag) * PWM_GAIN - PWM_OFFSET;
            r_rnum <= 16'(r_rmag) * PWM_GAIN - PWM_OFFSET;
        end
    end

    // Result register: load on hand-off, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_lcmp     <= (r_lmag == 9'd0) ? '0 : w_lcprod[CMP_SHIFT +: CMP_W];
            r_rcmp     <= (r_rmag == 9'd0) ? '0 : w_rcprod[CMP_SHIFT +: CMP_W];
            r_lfwd_out <= r_lfwd;
            r_rfwd_out <= r_rfwd;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_left_compare    = r_lcmp;
    assign o_right_compare   = r_rcmp;
    assign o_left_forward    = r_lfwd_out;
    assign o_right_forward   = r_rfwd_out;

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial drive command mixer testbench
// Feeds command bytes through the valid/ready input channel and takes wheel
// drive results with random stalls on both sides. A software copy of the
// parser and mixer predicts each drive result. Each result is checked field
// by field against the oldest prediction. The track term is rewritten
// between phases, with the block idle each time.
// ----------------------------------------------------------------------------

module tb;
    import sdcm_pkg::*;

    localparam int               CLK_HALF       = 5;
    localparam int               RESET_CYCLES   = 12;
    localparam int               MIX_LATENCY    = 10;
    localparam int               WATCHDOG_LIMIT = 1000;
    localparam int               TARGET_BYTES   = 1950;
    localparam logic [RX_W-1:0]  CH_PLUS        = 8'd43;   // '+'
    localparam logic [RX_W-1:0]  CH_NOISE       = 8'd120;  // 'x'

    typedef struct packed {
        logic [CMP_W-1:0] left_cmp;
        logic [CMP_W-1:0] right_cmp;
        logic             left_fwd;
        logic             right_fwd;
    } t_drive;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TRACK_W-1:0] i_cfg_wdata;

    sdcm_cmd_if cmd_if ();
    sdcm_drv_if drv_if ();

    serial_drive_command_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_if),
        .o_drv       (drv_if)
    );

    // Mirror of the parser state and the track term
    t_state              phase_model;
    logic                negative_model;
    logic signed [8:0]   linear_model;
    logic signed [8:0]   angular_model;
    logic [TRACK_W-1:0]  track_model;

    t_drive expected_drives[$];
    int     useful_bytes;
    int     drives_checked;
    int     track_writes;
    int     error_count;
    int     idle_cycles;
    bit     cmd_quiet;
    bit     drv_quiet;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    // PWM compare for one wheel speed
    function automatic logic [CMP_W-1:0] pwm_compare(int speed);
        int mag;
        mag = (speed < 0) ? -speed : speed;
        if (mag == 0)
            return '0;
        return CMP_W'((125 * mag - 7) / 10);
    endfunction

    // Advance the parser by one byte; queue a drive result on ESC
    task automatic parse_rx_byte(input logic [RX_W-1:0] b);
        int     turn;
        int     left;
        int     right;
        t_drive drv;
        case (phase_model)
            S_RECV: begin
                if (b == CH_LINEAR) begin
                    phase_model = S_LIN_SIGN;
                    useful_bytes++;
                end else if (b == CH_ANGULAR) begin
                    phase_model = S_ANG_SIGN;
                    useful_bytes++;
                end else if (b == CH_ESC) begin
                    turn  = (int'(angular_model) * int'(track_model)) / 100;
                    left  = (2 * int'(linear_model) - turn) / 2;
                    right = (2 * int'(linear_model) + turn) / 2;
                    drv.left_cmp  = pwm_compare(left);
                    drv.right_cmp = pwm_compare(right);
                    drv.left_fwd  = (left >= 0);
                    drv.right_fwd = (right >= 0);
                    expected_drives.push_back(drv);
                    phase_model = S_IDLE;
                    useful_bytes++;
                end
            end
            S_LIN_SIGN, S_ANG_SIGN: begin
                negative_model = (b == CH_MINUS);
                phase_model = (phase_model == S_LIN_SIGN) ? S_LIN_MAG : S_ANG_MAG;
                useful_bytes++;
            end
            S_LIN_MAG: begin
                linear_model = negative_model ? -$signed({1'b0, b}) : $signed({1'b0, b});
                phase_model = S_RECV;
                useful_bytes++;
            end
            S_ANG_MAG: begin
                angular_model = negative_model ? -$signed({1'b0, b}) : $signed({1'b0, b});
                phase_model = S_RECV;
                useful_bytes++;
            end
            default: begin
                if (b == CH_START) begin
                    phase_model = S_RECV;
                    useful_bytes++;
                end else begin
                    phase_model = S_IDLE;
                end
            end
        endcase
    endtask

    // Send one item; valid stays high on return so a back-to-back item can follow
    task automatic send_rx_byte(input logic [RX_W-1:0] b);
        int gap;
        gap = draw_wait(cmd_quiet);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.rx_byte <= b;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        parse_rx_byte(b);
    endtask

    // Drop valid, wait for every drive result, then let the mix pipeline empty
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (MIX_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_track(input logic [TRACK_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        track_model = value;
        track_writes++;
    endtask

    task automatic send_speed(input logic [RX_W-1:0] cmd, input logic [RX_W-1:0] sign,
                              input logic [RX_W-1:0] mag);
        send_rx_byte(cmd);
        send_rx_byte(sign);
        send_rx_byte(mag);
    endtask

    // Full frame: start, linear, angular, apply
    task automatic send_drive_frame(input bit lin_neg, input logic [RX_W-1:0] lin_mag,
                                    input bit ang_neg, input logic [RX_W-1:0] ang_mag);
        send_rx_byte(CH_START);
        send_speed(CH_LINEAR, lin_neg ? CH_MINUS : CH_PLUS, lin_mag);
        send_speed(CH_ANGULAR, ang_neg ? CH_MINUS : CH_PLUS, ang_mag);
        send_rx_byte(CH_ESC);
    endtask

    // Extremes, ignored bytes and control bytes taken as data
    task automatic test_directed();
        // ignored in idle, then apply the zero speeds after reset
        send_rx_byte(CH_ESC);
        send_rx_byte(CH_LINEAR);
        send_rx_byte(CH_START);
        send_rx_byte(CH_NOISE);
        send_rx_byte(CH_ESC);
        // full scale, opposite signs
        send_drive_frame(1'b0, 8'hff, 1'b1, 8'hff);
        // start byte while receiving is ignored; control bytes as sign and magnitude
        send_rx_byte(CH_START);
        send_rx_byte(CH_START);
        send_speed(CH_LINEAR, CH_START, CH_ESC);
        send_speed(CH_ANGULAR, CH_MINUS, CH_START);
        send_rx_byte(8'hff);
        send_rx_byte(CH_ESC);
        // negative zero magnitude
        send_rx_byte(CH_START);
        send_speed(CH_LINEAR, CH_MINUS, 8'h00);
        send_rx_byte(CH_ESC);
        settle();
    endtask

    // Track term at its extremes, above 100 included
    task automatic test_track_settings();
        logic [TRACK_W-1:0] tracks[5];
        tracks = '{7'd0, 7'd100, 7'd127, 7'd1, TRACK_RESET};
        foreach (tracks[i]) begin
            write_track(tracks[i]);
            send_drive_frame(1'b1, 8'hff, 1'b0, 8'hff);
            send_drive_frame(1'b0, 8'hff, 1'b1, 8'hff);
            send_drive_frame(1'b0, 8'h01, 1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    // Hold the sender until all results are back, with the receiver stalling
    task automatic test_drain_pause();
        drv_quiet = 1'b0;
        repeat (3)
            send_drive_frame(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        settle();
        send_drive_frame(1'b0, 8'd10, 1'b1, 8'd20);
        settle();
    endtask

    task automatic send_random_frame();
        int               fields;
        logic [RX_W-1:0]  sign;
        logic [RX_W-1:0]  mag;
        send_rx_byte(CH_START);
        fields = int'($urandom_range(0, 4));
        repeat (fields) begin
            if ($urandom_range(0, 9) == 0)
                send_rx_byte(8'($urandom_range(0, 255)));
            sign = $urandom_range(0, 1) ? CH_MINUS : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 5))
                0:       mag = 8'h00;
                1:       mag = 8'hff;
                default: mag = 8'($urandom_range(0, 255));
            endcase
            send_speed($urandom_range(0, 1) ? CH_LINEAR : CH_ANGULAR, sign, mag);
        end
        if ($urandom_range(0, 9) != 0)
            send_rx_byte(CH_ESC);
    endtask

    // Mostly well-formed frames with random content, some noise and broken frames
    task automatic test_random_traffic();
        int next_track_change;
        next_track_change = useful_bytes + 250;
        while (useful_bytes < TARGET_BYTES) begin
            if (useful_bytes >= next_track_change) begin
                case ($urandom_range(0, 3))
                    0:       write_track(7'd0);
                    1:       write_track(7'd127);
                    default: write_track(7'($urandom_range(0, 127)));
                endcase
                next_track_change = useful_bytes + 250;
            end
            if ($urandom_range(0, 39) == 0)
                cmd_quiet = ~cmd_quiet;
            if ($urandom_range(0, 39) == 0)
                drv_quiet = ~drv_quiet;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_rx_byte(8'($urandom_range(0, 255)));
            end else begin
                send_random_frame();
            end
        end
        settle();
    endtask

    // Take drive results with random stalls and check each one
    initial begin : drive_checker
        int     stall;
        t_drive want;
        drv_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(drv_quiet);
            if (stall > 0) begin
                drv_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            drv_if.ready <= 1'b1;
            do @(posedge i_clk); while (drv_if.valid !== 1'b1);
            if (expected_drives.size() == 0) begin
                $error("drive result with none expected");
                error_count++;
            end else begin
                want = expected_drives.pop_front();
                drives_checked++;
                if (drv_if.left_compare !== want.left_cmp) begin
                    $error("left_compare: expected %0d, got %0d",
                           want.left_cmp, drv_if.left_compare);
                    error_count++;
                end
                if (drv_if.right_compare !== want.right_cmp) begin
                    $error("right_compare: expected %0d, got %0d",
                           want.right_cmp, drv_if.right_compare);
                    error_count++;
                end
                if (drv_if.left_forward !== want.left_fwd) begin
                    $error("left_forward: expected %0d, got %0d",
                           want.left_fwd, drv_if.left_forward);
                    error_count++;
                end
                if (drv_if.right_forward !== want.right_fwd) begin
                    $error("right_forward: expected %0d, got %0d",
                           want.right_fwd, drv_if.right_forward);
                    error_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (drv_if.valid && drv_if.ready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        cmd_if.valid   <= 1'b0;
        cmd_if.rx_byte <= '0;
        idle_cycles    = 0;
        phase_model    = S_IDLE;
        negative_model = 1'b0;
        linear_model   = '0;
        angular_model  = '0;
        track_model    = TRACK_RESET;
        useful_bytes   = 0;
        drives_checked = 0;
        track_writes   = 0;
        error_count    = 0;
        cmd_quiet      = 1'b0;
        drv_quiet      = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_track_settings();
        test_drain_pause();
        test_random_traffic();

        if (expected_drives.size() != 0) begin
            $error("%0d drive results never arrived", expected_drives.size());
            error_count++;
        end
        $display("tb: %0d command bytes parsed, %0d drive results checked",
                 useful_bytes, drives_checked);
        $display("tb: %0d track term writes, %0d errors", track_writes, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[serial_drive_command_mixer.f]
+incdir+rtl
rtl/sdcm_pkg.sv
rtl/sdcm_if.sv
rtl/sdcm_ctrl.sv
rtl/sdcm_dp.sv
rtl/serial_drive_command_mixer.sv
sim/tb.sv
